### sv/sakt_pkg.sv
// Shared types and codes for the small associative key table.
// No dependencies; imported by the controller, the datapath and the top level.
package sakt_pkg;

    localparam int KEY_W = 16;
    localparam int VAL_W = 16;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_GET      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // latch the incoming operation
        logic lookup;    // compare all slots, register hit and free vectors
        logic execute;   // update the table and load the output register
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;  // output register holds a result that is not taken this cycle
    } dp_status_t;

endpackage

### sv/sakt_ctrl.sv
// Sequencer for the associative key table: capture, lookup, execute.
// Depends on sakt_pkg for the command and status structs.
module sakt_ctrl
    import sakt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t dp_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && ready_reg)
                    begin
                        state_reg <= S_LOOKUP;
                        ready_reg <= 1'b0;
                    end
                end
                S_LOOKUP:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    // hold until the output register can take the result
                    if (!dp_status.out_busy)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready    = ready_reg;
    assign cmd.capture = s_tvalid && ready_reg;
    assign cmd.lookup  = (state_reg == S_LOOKUP);
    assign cmd.execute = (state_reg == S_EXEC) && !dp_status.out_busy;

endmodule

### sv/sakt_dp.sv
// Datapath of the associative key table: slot storage, parallel compare,
// priority encoders and the output register. Depends on sakt_pkg.
module sakt_dp
    import sakt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         dp_status,
    input  mode_t              mode,
    input  logic [KEY_W-1:0]   key,
    input  logic [VAL_W-1:0]   value_in,
    output logic               m_tvalid,
    input  logic               m_tready,
    output status_t            status,
    output logic               found,
    output logic [VAL_W-1:0]   value_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] used_reg;
    logic [KEY_W-1:0] slot_key_reg   [SLOTS];
    logic [VAL_W-1:0] slot_value_reg [SLOTS];

    mode_t            mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_in_reg;

    logic [SLOTS-1:0] match_reg;
    logic [SLOTS-1:0] free_reg;

    logic             m_tvalid_reg;
    status_t          status_reg;
    logic             found_reg;
    logic [VAL_W-1:0] value_out_reg;

    logic             hit_any;
    logic             free_any;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;

    // lowest set bit of each vector
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any  = |match_reg;
    assign free_any = |free_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= mode;
            key_reg      <= key;
            value_in_reg <= value_in;
        end
        if (cmd.lookup)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                match_reg[i] <= used_reg[i] && (slot_key_reg[i] == key_reg);
            end
            free_reg <= ~used_reg;
        end
        if (cmd.execute && (mode_reg == MODE_ADD) && !hit_any && free_any)
        begin
            slot_key_reg[free_idx]   <= key_reg;
            slot_value_reg[free_idx] <= value_in_reg;
        end
        if (cmd.execute)
        begin
            found_reg     <= hit_any;
            value_out_reg <= '0;
            case (mode_reg)
                MODE_ADD:
                begin
                    if (hit_any)
                    begin
                        status_reg <= ST_PRESENT;
                    end
                    else if (free_any)
                    begin
                        status_reg <= ST_OK;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                MODE_GET:
                begin
                    status_reg <= hit_any ? ST_OK : ST_NOT_FOUND;
                    if (hit_any)
                    begin
                        value_out_reg <= slot_value_reg[hit_idx];
                    end
                end
                default:
                begin
                    status_reg <= hit_any ? ST_OK : ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                if ((mode_reg == MODE_ADD) && !hit_any && free_any)
                begin
                    used_reg[free_idx] <= 1'b1;
                end
                else if ((mode_reg == MODE_REMOVE) && hit_any)
                begin
                    used_reg[hit_idx] <= 1'b0;
                end
            end
            if (cmd.execute)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign value_out = value_out_reg;

endmodule

### sv/small_associative_key_table_unit.sv
// Top level of the small associative key table: stream ports around the
// sakt_ctrl sequencer and the sakt_dp datapath. Depends on sakt_pkg.
//
// Usage:
//   Operations enter on the slave stream. s_tuser carries the operation
//   (add, remove, contains, get); s_tdata carries the key and the value to
//   store on add. Every operation returns exactly one result on the master
//   stream: a status code, a found flag and, for a successful get, the
//   stored value.
//   Timing: an operation is taken in the capture step, all slots are
//   compared in the lookup step, and the table update and result load
//   happen in the execute step. The sakt_ctrl sequencer keeps s_tready low
//   from capture until the execute step is done, so a new operation is
//   not taken before the last one has loaded its result.
//   Stall: the finished result waits in the output register while the next
//   operation is taken and compared; the execute step holds until that
//   register is free, so results are never dropped or reordered.
//   Reset: all slots are marked free at once; no clearing pass is needed,
//   and s_tready is high from the first cycle after reset.
module small_associative_key_table_unit
    import sakt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] key, [31:16] value_in
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [2] found, [18:3] value_out, [23:19] zero
);

    dp_cmd_t          cmd;
    dp_status_t       dp_status;
    status_t          status;
    logic             found;
    logic [VAL_W-1:0] value_out;

    // Sequencer: owns s_tready and steps each operation through
    // capture, lookup and execute.
    sakt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

    // Slot storage, compare and output register.
    sakt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dp_status (dp_status),
        .mode      (mode_t'(s_tuser)),
        .key       (s_tdata[15:0]),
        .value_in  (s_tdata[31:16]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .found     (found),
        .value_out (value_out)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {5'd0, value_out, found, status};

endmodule
